// ===== rtl/dltq_pkg.sv =====
`timescale 1ns / 1ps

package dltq_pkg;

   // Default sizing of the timer list.
   localparam int DLTQ_DEPTH     = 16;
   localparam int DLTQ_TIME_BITS = 24;
   localparam int DLTQ_SEQ_BITS  = 32;

   // Fixed widths of the channel fields.
   localparam int MODE_W = 2;
   localparam int SEQ_W  = 32;
   localparam int DUR_W  = 24;
   localparam int KIND_W = 3;

   // Request operation codes.
   typedef enum logic [MODE_W-1:0] {
      MODE_TICK   = 2'd0,
      MODE_SET    = 2'd1,
      MODE_CANCEL = 2'd2
   } mode_type;

   // Result codes.
   typedef enum logic [KIND_W-1:0] {
      KIND_SET_OK    = 3'd0,
      KIND_SET_FULL  = 3'd1,
      KIND_CANCELLED = 3'd2,
      KIND_NOT_FOUND = 3'd3,
      KIND_EXPIRED   = 3'd4
   } kind_type;

   // One result on its way from the sequencer to the output register.
   typedef struct packed {
      kind_type          kind;
      logic [SEQ_W-1:0]  seq;
   } result_type;

endpackage

// ===== rtl/dltq_if.sv =====
`timescale 1ns / 1ps

// Request channel: one timer command per transaction.
interface dltq_req_if;
   logic                        valid;
   logic                        ready;
   logic [dltq_pkg::MODE_W-1:0] mode;
   logic [dltq_pkg::SEQ_W-1:0]  seq_number;
   logic [dltq_pkg::DUR_W-1:0]  duration;

   modport source (output valid, output mode, output seq_number, output duration,
                   input ready);
   modport sink   (input valid, input mode, input seq_number, input duration,
                   output ready);
endinterface

// Response channel: one result per transaction.
interface dltq_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dltq_pkg::KIND_W-1:0] kind;
   logic [dltq_pkg::SEQ_W-1:0]  seq_out;

   modport source (output valid, output kind, output seq_out, input ready);
   modport sink   (input valid, input kind, input seq_out, output ready);
endinterface

// ===== rtl/dltq_mem.sv =====
`timescale 1ns / 1ps

module dltq_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 56
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/dltq_seq.sv =====
`timescale 1ns / 1ps

module dltq_seq #(
   parameter int DEPTH     = 16,
   parameter int TIME_BITS = 24,
   parameter int SEQ_BITS  = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   dltq_req_if.sink                              req,
   output logic                                  mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]              mem_wr_addr,
   output logic [SEQ_BITS+TIME_BITS-1:0]         mem_wr_data,
   output logic [$clog2(DEPTH)-1:0]              mem_rd_addr,
   input  logic [SEQ_BITS+TIME_BITS-1:0]         mem_rd_data,
   output logic                                  res_valid,
   input  logic                                  res_ready,
   output dltq_pkg::result_type                  res
);

   import dltq_pkg::*;

   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);
   localparam int DATA_BITS = SEQ_BITS + TIME_BITS;

   typedef enum logic [3:0] {
      S_IDLE,
      S_TICK,
      S_SET_HEAD,
      S_WALK,
      S_SHIFT_RD,
      S_SHIFT,
      S_SET_FIX,
      S_SET_WRITE,
      S_FIND,
      S_CAN_FOLD,
      S_CAN_SHIFT,
      S_CAN_DONE,
      S_RESULT
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  fired_ff, fired_in;
   logic [CNT_BITS-1:0]   idx_ff, idx_in;
   logic [CNT_BITS-1:0]   sp_ff, sp_in;
   logic [SEQ_BITS-1:0]   seq_ff, seq_in;
   logic [TIME_BITS-1:0]  t_ff, t_in;
   logic [SEQ_BITS-1:0]   stop_seq_ff, stop_seq_in;
   logic [TIME_BITS-1:0]  stop_delta_ff, stop_delta_in;
   kind_type              res_kind_ff, res_kind_in;
   logic [SEQ_BITS-1:0]   res_seq_ff, res_seq_in;

   logic [SEQ_BITS-1:0]   rd_seq;
   logic [TIME_BITS-1:0]  rd_delta;
   logic [SEQ_BITS-1:0]   req_seq;
   logic [31:0]           req_dur_wide;
   logic [TIME_BITS-1:0]  req_dur;
   logic [TIME_BITS-1:0]  tick_delta;
   logic [CNT_BITS-1:0]   idx_p1, idx_p2, sp_p1, sp_m1, cnt_p1, cnt_m1;
   logic [CNT_BITS-1:0]   rd_index, wr_index;

   // Entry fields as read back from the list memory.
   assign rd_seq   = mem_rd_data[DATA_BITS-1 -: SEQ_BITS];
   assign rd_delta = mem_rd_data[TIME_BITS-1:0];

   // Request fields reduced to the stored widths.
   assign req_seq      = req.seq_number[SEQ_BITS-1:0];
   assign req_dur_wide = 32'(req.duration);
   assign req_dur      = req_dur_wide[TIME_BITS-1:0];

   assign idx_p1 = idx_ff + CNT_BITS'(1);
   assign idx_p2 = idx_ff + CNT_BITS'(2);
   assign sp_p1  = sp_ff + CNT_BITS'(1);
   assign sp_m1  = sp_ff - CNT_BITS'(1);
   assign cnt_p1 = count_ff + CNT_BITS'(1);
   assign cnt_m1 = count_ff - CNT_BITS'(1);

   // The head counts down but stops at zero.
   assign tick_delta = (rd_delta != '0) ? rd_delta - TIME_BITS'(1) : rd_delta;

   assign req.ready = (state_ff == S_IDLE);

   // Read address: each state fetches the entry that the next state works on.
   always_comb begin
      case (state_ff)
         S_SET_HEAD:  rd_index = CNT_BITS'(1);
         S_WALK:      rd_index = idx_p1;
         S_SHIFT_RD:  rd_index = cnt_m1;
         S_SHIFT:     rd_index = sp_m1;
         S_FIND:      rd_index = idx_p1;
         S_CAN_FOLD:  rd_index = idx_p2;
         S_CAN_SHIFT: rd_index = sp_p1;
         default:     rd_index = '0;
      endcase
   end

   assign mem_rd_addr = rd_index[ADDR_BITS-1:0];
   assign mem_wr_addr = wr_index[ADDR_BITS-1:0];

   // Sequencer: walks the list, shifts entries and writes back.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      fired_in      = fired_ff;
      idx_in        = idx_ff;
      sp_in         = sp_ff;
      seq_in        = seq_ff;
      t_in          = t_ff;
      stop_seq_in   = stop_seq_ff;
      stop_delta_in = stop_delta_ff;
      res_kind_in   = res_kind_ff;
      res_seq_in    = res_seq_ff;
      mem_wr_en     = 1'b0;
      wr_index      = '0;
      mem_wr_data   = mem_rd_data;
      res_valid     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               seq_in = req_seq;
               t_in   = req_dur;
               idx_in = '0;
               case (req.mode)
                  MODE_TICK: begin
                     if (count_ff != '0 && !fired_ff) begin
                        state_in = S_TICK;
                     end
                  end
                  MODE_SET: begin
                     if (count_ff == CNT_BITS'(DEPTH)) begin
                        res_kind_in = KIND_SET_FULL;
                        res_seq_in  = req_seq;
                        state_in    = S_RESULT;
                     end else if (fired_ff) begin
                        state_in = S_SET_HEAD;
                     end else if (count_ff == '0) begin
                        state_in = S_SET_WRITE;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  MODE_CANCEL: begin
                     if (count_ff == '0) begin
                        res_kind_in = KIND_NOT_FOUND;
                        res_seq_in  = req_seq;
                        state_in    = S_RESULT;
                     end else begin
                        state_in = S_FIND;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Count the head down and report expiry when it reaches zero.
         S_TICK: begin
            mem_wr_en   = 1'b1;
            wr_index    = '0;
            mem_wr_data = {rd_seq, tick_delta};
            if (tick_delta == '0) begin
               fired_in    = 1'b1;
               res_kind_in = KIND_EXPIRED;
               res_seq_in  = rd_seq;
               state_in    = S_RESULT;
            end else begin
               state_in = S_IDLE;
            end
         end

         // A fired head stays in front; the new timer starts behind it.
         S_SET_HEAD: begin
            t_in   = (t_ff >= rd_delta) ? t_ff - rd_delta : '0;
            idx_in = CNT_BITS'(1);
            if (count_ff == CNT_BITS'(1)) begin
               state_in = S_SET_WRITE;
            end else begin
               state_in = S_WALK;
            end
         end

         // Skip entries that expire strictly earlier than the new timer.
         S_WALK: begin
            if (rd_delta < t_ff) begin
               t_in   = t_ff - rd_delta;
               idx_in = idx_p1;
               if (idx_p1 == count_ff) begin
                  state_in = S_SET_WRITE;
               end
            end else begin
               stop_seq_in   = rd_seq;
               stop_delta_in = rd_delta;
               if (idx_p1 == count_ff) begin
                  state_in = S_SET_FIX;
               end else begin
                  state_in = S_SHIFT_RD;
               end
            end
         end

         S_SHIFT_RD: begin
            sp_in    = cnt_m1;
            state_in = S_SHIFT;
         end

         // Move entries up by one, last first, one entry per cycle.
         S_SHIFT: begin
            mem_wr_en   = 1'b1;
            wr_index    = sp_p1;
            mem_wr_data = mem_rd_data;
            if (sp_ff == idx_p1) begin
               state_in = S_SET_FIX;
            end else begin
               sp_in = sp_m1;
            end
         end

         // The displaced entry keeps only what is left after the new timer.
         S_SET_FIX: begin
            mem_wr_en   = 1'b1;
            wr_index    = idx_p1;
            mem_wr_data = {stop_seq_ff, stop_delta_ff - t_ff};
            state_in    = S_SET_WRITE;
         end

         S_SET_WRITE: begin
            mem_wr_en   = 1'b1;
            wr_index    = idx_ff;
            mem_wr_data = {seq_ff, t_ff};
            count_in    = cnt_p1;
            res_kind_in = KIND_SET_OK;
            res_seq_in  = seq_ff;
            state_in    = S_RESULT;
         end

         // Search for the first entry with the requested sequence number.
         S_FIND: begin
            if (rd_seq == seq_ff) begin
               stop_delta_in = rd_delta;
               if (idx_p1 == count_ff) begin
                  state_in = S_CAN_DONE;
               end else begin
                  state_in = S_CAN_FOLD;
               end
            end else if (idx_p1 == count_ff) begin
               res_kind_in = KIND_NOT_FOUND;
               res_seq_in  = seq_ff;
               state_in    = S_RESULT;
            end else begin
               idx_in = idx_p1;
            end
         end

         // The successor takes the removed slot and absorbs its delta.
         S_CAN_FOLD: begin
            mem_wr_en   = 1'b1;
            wr_index    = idx_ff;
            mem_wr_data = {rd_seq, rd_delta + stop_delta_ff};
            if (idx_p2 < count_ff) begin
               sp_in    = idx_p2;
               state_in = S_CAN_SHIFT;
            end else begin
               state_in = S_CAN_DONE;
            end
         end

         // Move the remaining entries down by one.
         S_CAN_SHIFT: begin
            mem_wr_en   = 1'b1;
            wr_index    = sp_m1;
            mem_wr_data = mem_rd_data;
            if (sp_p1 == count_ff) begin
               state_in = S_CAN_DONE;
            end else begin
               sp_in = sp_p1;
            end
         end

         S_CAN_DONE: begin
            count_in = cnt_m1;
            if (idx_ff == '0) begin
               fired_in = 1'b0;
            end
            res_kind_in = KIND_CANCELLED;
            res_seq_in  = seq_ff;
            state_in    = S_RESULT;
         end

         // Hold the result until the output register takes it.
         S_RESULT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign res.kind = res_kind_ff;
   assign res.seq  = SEQ_W'(res_seq_ff);

   // State and working registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         fired_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         fired_ff <= fired_in;
      end
      idx_ff        <= idx_in;
      sp_ff         <= sp_in;
      seq_ff        <= seq_in;
      t_ff          <= t_in;
      stop_seq_ff   <= stop_seq_in;
      stop_delta_ff <= stop_delta_in;
      res_kind_ff   <= res_kind_in;
      res_seq_ff    <= res_seq_in;
   end

   // The list never holds more than DEPTH timers.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("timer count exceeds depth");

   // A fired head implies a non-empty list.
   a_fired_nonempty: assert property (@(posedge clock) disable iff (reset)
      fired_ff |-> count_ff != '0)
      else $error("fired flag set on an empty list");

   // Shift steps never write the entry that is being fetched in the same cycle.
   a_shift_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT || state_ff == S_CAN_SHIFT || state_ff == S_CAN_FOLD)
      |-> mem_wr_addr != mem_rd_addr)
      else $error("shift write collides with read");

   // The count changes only when an insert or a removal completes.
   a_count_change: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(count_ff))
      |-> ($past(state_ff) == S_SET_WRITE || $past(state_ff) == S_CAN_DONE))
      else $error("timer count changed outside insert or removal");

endmodule

// ===== rtl/delta_list_timer_queue.sv =====
`timescale 1ns / 1ps

// Delta-list timer queue.
// Commands arrive on req_chan (valid/ready): tick, set timer or cancel timer,
// with a sequence number and, for set, a duration in ticks. Results leave on
// rsp_chan (valid/ready) with a kind code and the sequence number concerned.
// A tick gives a result only when the head timer expires; set and cancel always
// give one. Timers live in one list memory (one write and one registered read
// per cycle), ordered by expiry, each storing its delta to the one before.
// Commands are taken one at a time. A tick works on the head entry only; set and
// cancel take longer the more timers are live, owing to the list walk and the
// one-entry-per-cycle shift through the memory port. A result sits in
// an output register; the next command is accepted and worked on while it
// waits, but that command's result, and so the command after it, is held until
// the receiver has taken the earlier result.
// Reset clears the timer count and the expiry flag; the memory is not cleared
// because only live entries are ever read.

module delta_list_timer_queue #(
   parameter int DEPTH     = dltq_pkg::DLTQ_DEPTH,
   parameter int TIME_BITS = dltq_pkg::DLTQ_TIME_BITS,
   parameter int SEQ_BITS  = dltq_pkg::DLTQ_SEQ_BITS
) (
   input  logic       clock,
   input  logic       reset,
   dltq_req_if.sink   req_chan,
   dltq_rsp_if.source rsp_chan
);

   import dltq_pkg::*;

   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int DATA_BITS = SEQ_BITS + TIME_BITS;

   logic                 mem_wr_en;
   logic [ADDR_BITS-1:0] mem_wr_addr;
   logic [DATA_BITS-1:0] mem_wr_data;
   logic [ADDR_BITS-1:0] mem_rd_addr;
   logic [DATA_BITS-1:0] mem_rd_data;
   logic                 res_valid;
   logic                 res_ready;
   result_type           res;

   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_res_ff, rsp_res_in;

   dltq_seq #(
      .DEPTH     (DEPTH),
      .TIME_BITS (TIME_BITS),
      .SEQ_BITS  (SEQ_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   dltq_mem #(
      .DEPTH (DEPTH),
      .WIDTH (DATA_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Output register: takes a new result when empty or being drained.
   assign res_ready = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.kind    = rsp_res_ff.kind;
   assign rsp_chan.seq_out = rsp_res_ff.seq;

endmodule
